// ===== src/srm_pkg.sv =====
// Package for the snapshot redirect map: widths, codes, state and map-port types.
// Used by the channel interfaces, the sequencer and the top level.
package srm_pkg;

   localparam int BLOCK_SHIFT     = 3;
   localparam int BLK_SECTORS     = 1 << BLOCK_SHIFT;
   localparam int MAP_DEPTH       = 65536;
   localparam int MAP_AW          = $clog2(MAP_DEPTH);
   localparam int MAX_REQ_SECTORS = 256;
   localparam int ENTRY_W         = 30;
   localparam int MAP_W           = ENTRY_W + 1;
   localparam int START_W         = 19;
   localparam int CNT_W           = 9;
   localparam int BUF_W           = 16;
   localparam int BUFOUT_W        = 17;
   localparam int SNAP_W          = 32;
   localparam int DEV_W           = 17;
   localparam int OFF_W           = CNT_W + 1;
   localparam int IDX_W           = START_W + 1 - BLOCK_SHIFT;
   localparam int SUB_W           = BLOCK_SHIFT + 1;
   localparam int CUR_W           = ENTRY_W + BLOCK_SHIFT;
   localparam int DEV_RESET       = 65536;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNMAPPED  = 2'd1,
      ST_NO_SPACE  = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      CSR_STORE_LIMIT   = 1'b0,
      CSR_DEVICE_BLOCKS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WRITE,
      S_READ,
      S_READ_LAST,
      S_SINGLE
   } state_type;

   typedef struct packed {
      logic              base_en;
      logic              write_en;
      logic [MAP_AW-1:0] addr;
      logic [MAP_W-1:0]  data;
   } map_wr_type;

endpackage

// ===== src/srm_if.sv =====
// Channel interfaces for the snapshot redirect map: request, response, register write.
// Field widths come from srm_pkg.
interface srm_req_if;
   logic                        valid;
   logic                        ready;
   logic                        action;
   logic                        map_select;
   logic [srm_pkg::START_W-1:0] start_sector;
   logic [srm_pkg::CNT_W-1:0]   sector_count;
   logic [srm_pkg::BUF_W-1:0]   buffer_start;
   modport source (output valid, action, map_select, start_sector, sector_count,
                   buffer_start, input ready);
   modport sink (input valid, action, map_select, start_sector, sector_count,
                 buffer_start, output ready);
endinterface

interface srm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   status;
   logic [srm_pkg::SNAP_W-1:0]   snap_sector;
   logic [srm_pkg::BUFOUT_W-1:0] buffer_sector;
   logic [srm_pkg::CNT_W-1:0]    run_sectors;
   logic                         last;
   modport source (output valid, status, snap_sector, buffer_sector, run_sectors, last,
                   input ready);
   modport sink (input valid, status, snap_sector, buffer_sector, run_sectors, last,
                 output ready);
endinterface

interface srm_csr_if;
   logic                       valid;
   logic                       ready;
   logic                       index;
   logic [srm_pkg::SNAP_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/srm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module srm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/srm_engine.sv =====
// Sequencer of the snapshot redirect map: clearing pass, extent recording,
// read translation with run merging, and the response register. Uses srm_pkg.
module srm_engine (
   input  logic                        clock,
   input  logic                        reset,
   srm_req_if.sink                     req,
   srm_rsp_if.source                   rsp,
   input  logic [srm_pkg::SNAP_W-1:0]  store_limit,
   input  logic [srm_pkg::DEV_W-1:0]   device_blocks,
   output srm_pkg::map_wr_type         map_wr,
   output logic [srm_pkg::MAP_AW-1:0]  map_rd_addr,
   input  logic [srm_pkg::MAP_W-1:0]   base_rd,
   input  logic [srm_pkg::MAP_W-1:0]   write_rd
);
   import srm_pkg::*;

   state_type            state_ff, state_in;
   logic [MAP_AW-1:0]    clr_ff, clr_in;
   logic                 sel_ff, sel_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [BUF_W-1:0]     bufst_ff, bufst_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic                 first_ff, first_in;
   logic [CUR_W-1:0]     prev_ff, prev_in;
   logic [SUB_W-1:0]     plen_ff, plen_in;
   logic [CUR_W-1:0]     run_start_ff, run_start_in;
   logic [CNT_W-1:0]     runlen_ff, runlen_in;
   logic [CNT_W-1:0]     bufofs_ff, bufofs_in;
   logic [SNAP_W-1:0]    alloc_ff, alloc_in;
   status_type           res_status_ff, res_status_in;
   logic [SNAP_W-1:0]    res_snap_ff, res_snap_in;
   logic [CNT_W-1:0]     res_run_ff, res_run_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SNAP_W-1:0]    rsp_snap_ff, rsp_snap_in;
   logic [BUFOUT_W-1:0]  rsp_buf_ff, rsp_buf_in;
   logic [CNT_W-1:0]     rsp_run_ff, rsp_run_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 can_emit;
   logic [CNT_W-1:0]     cnt_sat;
   logic [IDX_W-1:0]     chk_idx, nxt_idx;
   logic                 chk_ok;
   logic                 hit;
   logic [CUR_W-1:0]     cur, cur_first;
   logic [SUB_W-1:0]     unord, plen_first, mlen;
   logic [CNT_W-1:0]     rem;
   logic [OFF_W-1:0]     next_off;
   logic                 merge;
   logic [ENTRY_W-1:0]   wr_val;
   logic [BUFOUT_W-1:0]  buf_pos;

   function automatic logic idx_ok(input logic [IDX_W-1:0] idx,
                                   input logic [DEV_W-1:0] dev);
      return (32'(idx) < 32'(dev)) && (32'(idx) < 32'(MAP_DEPTH));
   endfunction

   assign can_emit = !rsp_valid_ff || rsp.ready;
   assign cnt_sat  = (req.sector_count > CNT_W'(MAX_REQ_SECTORS)) ?
                     CNT_W'(MAX_REQ_SECTORS) : req.sector_count;

   // The block index being looked up now, and the one that follows it.
   assign chk_idx  = IDX_W'(({1'b0, start_ff} + (START_W+1)'(off_ff)) >> BLOCK_SHIFT);
   assign chk_ok   = idx_ok(chk_idx, device_blocks);
   assign hit      = write_rd[MAP_W-1] || base_rd[MAP_W-1];
   assign cur      = write_rd[MAP_W-1] ? {write_rd[ENTRY_W-1:0], BLOCK_SHIFT'(0)} :
                                         {base_rd[ENTRY_W-1:0], BLOCK_SHIFT'(0)};
   assign unord    = SUB_W'(start_ff & START_W'(BLK_SECTORS - 1));
   assign cur_first = cur | CUR_W'(unord);
   assign plen_first = ((CNT_W'(SUB_W'(BLK_SECTORS) - unord)) > cnt_ff) ?
                       SUB_W'(cnt_ff) : SUB_W'(BLK_SECTORS) - unord;
   assign rem      = cnt_ff - CNT_W'(off_ff);
   assign mlen     = (rem > CNT_W'(BLK_SECTORS)) ? SUB_W'(BLK_SECTORS) : SUB_W'(rem);
   assign next_off = first_ff ? OFF_W'(plen_first) : off_ff + OFF_W'(BLK_SECTORS);
   assign nxt_idx  = IDX_W'(({1'b0, start_ff} + (START_W+1)'(next_off)) >> BLOCK_SHIFT);
   assign merge    = ({1'b0, prev_ff} + (CUR_W+1)'(plen_ff)) == {1'b0, cur};
   assign wr_val   = ENTRY_W'(({1'b0, res_snap_ff} + (SNAP_W+1)'(off_ff)) >> BLOCK_SHIFT);
   assign buf_pos  = BUFOUT_W'(bufst_ff) + BUFOUT_W'(bufofs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         alloc_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         alloc_ff     <= alloc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sel_ff        <= sel_in;
      start_ff      <= start_in;
      cnt_ff        <= cnt_in;
      bufst_ff      <= bufst_in;
      off_ff        <= off_in;
      first_ff      <= first_in;
      prev_ff       <= prev_in;
      plen_ff       <= plen_in;
      run_start_ff  <= run_start_in;
      runlen_ff     <= runlen_in;
      bufofs_ff     <= bufofs_in;
      res_status_ff <= res_status_in;
      res_snap_ff   <= res_snap_in;
      res_run_ff    <= res_run_in;
      rsp_status_ff <= rsp_status_in;
      rsp_snap_ff   <= rsp_snap_in;
      rsp_buf_ff    <= rsp_buf_in;
      rsp_run_ff    <= rsp_run_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      sel_in        = sel_ff;
      start_in      = start_ff;
      cnt_in        = cnt_ff;
      bufst_in      = bufst_ff;
      off_in        = off_ff;
      first_in      = first_ff;
      prev_in       = prev_ff;
      plen_in       = plen_ff;
      run_start_in  = run_start_ff;
      runlen_in     = runlen_ff;
      bufofs_in     = bufofs_ff;
      alloc_in      = alloc_ff;
      res_status_in = res_status_ff;
      res_snap_in   = res_snap_ff;
      res_run_in    = res_run_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_snap_in   = rsp_snap_ff;
      rsp_buf_in    = rsp_buf_ff;
      rsp_run_in    = rsp_run_ff;
      rsp_last_in   = rsp_last_ff;
      map_wr        = '0;
      // Re-reading the same entry keeps the RAM output steady during a stall.
      map_rd_addr   = MAP_AW'(chk_idx);

      case (state_ff)
         S_CLEAR: begin
            map_wr.base_en  = 1'b1;
            map_wr.write_en = 1'b1;
            map_wr.addr     = clr_ff;
            clr_in          = clr_ff + 1'b1;
            if (clr_ff == MAP_AW'(MAP_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            map_rd_addr = MAP_AW'(req.start_sector >> BLOCK_SHIFT);
            if (req.valid) begin
               sel_in    = req.map_select;
               start_in  = req.start_sector;
               cnt_in    = cnt_sat;
               bufst_in  = req.buffer_start;
               off_in    = '0;
               first_in  = 1'b1;
               runlen_in = '0;
               bufofs_in = '0;
               res_status_in = ST_OK;
               res_snap_in   = '0;
               res_run_in    = '0;
               if (cnt_sat == '0) begin
                  state_in = S_SINGLE;
               end else if (!req.action) begin
                  res_snap_in = alloc_ff;
                  if (({1'b0, alloc_ff} + (SNAP_W+1)'(cnt_sat)) > {1'b0, store_limit}) begin
                     res_status_in = ST_NO_SPACE;
                     state_in      = S_SINGLE;
                  end else begin
                     alloc_in   = alloc_ff + SNAP_W'(cnt_sat);
                     res_run_in = cnt_sat;
                     state_in   = S_WRITE;
                  end
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_WRITE: begin
            if (off_ff < OFF_W'(cnt_ff)) begin
               if (chk_ok) begin
                  map_wr.base_en  = !sel_ff;
                  map_wr.write_en = sel_ff;
                  map_wr.addr     = MAP_AW'(chk_idx);
                  map_wr.data     = {1'b1, wr_val};
                  off_in          = off_ff + OFF_W'(BLK_SECTORS);
               end else begin
                  res_status_in = ST_RANGE;
                  state_in      = S_SINGLE;
               end
            end else begin
               state_in = S_SINGLE;
            end
         end
         S_SINGLE: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_snap_in   = res_snap_ff;
               rsp_buf_in    = '0;
               rsp_run_in    = res_run_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_READ: begin
            if (!chk_ok || !hit) begin
               if (can_emit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = chk_ok ? ST_UNMAPPED : ST_RANGE;
                  rsp_snap_in   = '0;
                  rsp_buf_in    = '0;
                  rsp_run_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (first_ff || merge || can_emit) begin
               if (first_ff) begin
                  prev_in      = cur_first;
                  run_start_in = cur_first;
                  runlen_in    = CNT_W'(plen_first);
                  plen_in      = plen_first;
               end else begin
                  prev_in = cur;
                  plen_in = mlen;
                  if (merge) begin
                     runlen_in = runlen_ff + CNT_W'(mlen);
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OK;
                     rsp_snap_in   = run_start_ff[SNAP_W-1:0];
                     rsp_buf_in    = buf_pos;
                     rsp_run_in    = runlen_ff;
                     rsp_last_in   = 1'b0;
                     bufofs_in     = bufofs_ff + runlen_ff;
                     run_start_in  = cur;
                     runlen_in     = CNT_W'(mlen);
                  end
               end
               first_in = 1'b0;
               off_in   = next_off;
               if (next_off < OFF_W'(cnt_ff)) begin
                  map_rd_addr = MAP_AW'(nxt_idx);
               end else begin
                  state_in = S_READ_LAST;
               end
            end
         end
         S_READ_LAST: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_snap_in   = run_start_ff[SNAP_W-1:0];
               rsp_buf_in    = buf_pos;
               rsp_run_in    = runlen_ff;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req.ready         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.status        = rsp_status_ff;
   assign rsp.snap_sector   = rsp_snap_ff;
   assign rsp.buffer_sector = rsp_buf_ff;
   assign rsp.run_sectors   = rsp_run_ff;
   assign rsp.last          = rsp_last_ff;
endmodule

// ===== src/snapshot_redirect_map.sv =====
// Top level of the snapshot redirect map: register file, the two map RAMs and the sequencer.
// Depends on srm_pkg, srm_if, srm_ram and srm_engine.

// One transaction is handled at a time. After reset a clearing pass writes every map
// entry before the first request is taken; register writes are taken throughout. A
// write makes one map write per block, and a read walks one block per cycle through
// both maps, which are read in parallel from registered RAM outputs. The largest
// request spans 33 blocks. A full response register stalls the walk when a finished
// run must be sent.
module snapshot_redirect_map (
   input  logic       clock,
   input  logic       reset,
   srm_req_if.sink    req,
   srm_rsp_if.source  rsp,
   srm_csr_if.sink    csr
);
   import srm_pkg::*;

   logic [SNAP_W-1:0] store_limit_ff;
   logic [DEV_W-1:0]  device_blocks_ff;
   map_wr_type        map_wr;
   logic [MAP_AW-1:0] map_rd_addr;
   logic [MAP_W-1:0]  base_rd;
   logic [MAP_W-1:0]  write_rd;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         store_limit_ff   <= '0;
         device_blocks_ff <= DEV_W'(DEV_RESET);
      end else if (csr.valid) begin
         case (csr_index_type'(csr.index))
            CSR_STORE_LIMIT:   store_limit_ff   <= csr.data;
            CSR_DEVICE_BLOCKS: device_blocks_ff <= csr.data[DEV_W-1:0];
            default: ;
         endcase
      end
   end

   srm_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_base_map (
      .clock   (clock),
      .wr_en   (map_wr.base_en),
      .wr_addr (map_wr.addr),
      .wr_data (map_wr.data),
      .rd_addr (map_rd_addr),
      .rd_data (base_rd)
   );

   srm_ram #(.WIDTH(MAP_W), .DEPTH(MAP_DEPTH)) u_write_map (
      .clock   (clock),
      .wr_en   (map_wr.write_en),
      .wr_addr (map_wr.addr),
      .wr_data (map_wr.data),
      .rd_addr (map_rd_addr),
      .rd_data (write_rd)
   );

   srm_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req           (req),
      .rsp           (rsp),
      .store_limit   (store_limit_ff),
      .device_blocks (device_blocks_ff),
      .map_wr        (map_wr),
      .map_rd_addr   (map_rd_addr),
      .base_rd       (base_rd),
      .write_rd      (write_rd)
   );

   // The clearing pass must hold off requests right after reset.
   a_clear_after_reset: assert property (@(posedge clock) reset |=> !req.ready)
      else $error("request taken before the map clearing pass");

   // Only one transaction is in flight at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request taken while another is in progress");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status != ST_OK) |-> rsp.last)
      else $error("error response not marked last");

   a_no_space_empty: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.status == ST_NO_SPACE) |-> (rsp.run_sectors == '0))
      else $error("out-of-space response carries a length");
endmodule
